/* design/fifo_queue_with_content_stats_top_defines.svh */
// assertion macros for the fifo queue with content statistics
// used by the checker; needs clk and rst_n in the scope of each use
`ifndef FIFO_QUEUE_WITH_CONTENT_STATS_TOP_DEFINES_SVH
`define FIFO_QUEUE_WITH_CONTENT_STATS_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FQCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FQCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/fqcs_pkg.sv */
// shared types and codes of the fifo queue with content statistics
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fqcs_pkg;

    // request codes
    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_RPT = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // result field widths
    localparam int OUTV_W  = 32;
    localparam int FILL_W  = 4;
    localparam int LARGE_W = 31;
    localparam int TOTAL_W = 35;
    localparam int MEAN_W  = 40;
    localparam int CNT4_W  = 4;
    localparam int VALUE_W = 32;

    // request payload, op in the low bits
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                op;
    } in_t;

    // result payload, status in the low bits
    typedef struct packed {
        logic [CNT4_W-1:0]         odd_count;
        logic [CNT4_W-1:0]         even_count;
        logic signed [MEAN_W-1:0]  mean_q8;
        logic signed [TOTAL_W-1:0] total;
        logic [LARGE_W-1:0]        smallest;
        logic [LARGE_W-1:0]        largest;
        logic                      is_empty;
        logic                      is_full;
        logic [FILL_W-1:0]         fill_count;
        logic signed [OUTV_W-1:0]  out_value;
        logic [1:0]                status;
    } res_t;

    localparam int IN_W        = $bits(in_t);
    localparam int RES_W       = $bits(res_t);
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* design/fqcs_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fqcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/fifo_queue_with_content_stats_top.sv */
// top level of the fifo queue with content statistics
// depends on fqcs_pkg and fqcs_ram
`timescale 1ns / 1ps
`default_nettype none

// Bounded FIFO of signed words. Each request on the slave stream enqueues,
// dequeues or only reports; a full enqueue or an empty dequeue is refused
// with a status code and changes nothing. Every request gives one result on
// the master stream with the fill level, full/empty flags and statistics of
// the contents after the request: largest (max of zero and all entries),
// smallest positive entry, total, mean in signed Q.8 truncated toward zero,
// and even/odd counts. One request is handled at a time; the result
// becomes valid in the same cycle that the next request can be taken.
// A dequeue first reads the head word from the ram. When the contents are
// empty after the request the divider is skipped. The time per request is
// set by a walk over the held entries through the single ram read port,
// one entry a cycle, by a restoring divider that produces one quotient bit
// a cycle over the scaled total, and by any wait for the output register.
// The result sits in an output register, so a new request can be taken
// while the previous result waits to be read.

module fifo_queue_with_content_stats_top #(
    parameter int DEPTH     = 8,
    parameter int WORD_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // request stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata from bit 0: op[1:0], value[31:0], zero pad
    input  wire logic [fqcs_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata from bit 0: status[1:0], out_value[31:0], fill_count[3:0],
    // is_full, is_empty, largest[30:0], smallest[30:0], total[34:0],
    // mean_q8[39:0], even_count[3:0], odd_count[3:0], zero pad
    output logic [fqcs_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    import fqcs_pkg::*;

    // sizes derived from the parameters
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = WORD_BITS + CNT_W;   // sum of all entries
    localparam int DIV_W      = SUM_W + 8;           // |total| scaled by 256
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEQ  = 3'd1;   // head word arrives from ram
    localparam logic [2:0] S_WALK = 3'd2;   // one entry per cycle into stats
    localparam logic [2:0] S_DIV  = 3'd3;   // one quotient bit per cycle
    localparam logic [2:0] S_OUT  = 3'd4;   // hand result to output register

    // circular pointer add with wrap at DEPTH
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                    input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ADDR_W + 1)'(DEPTH))
        begin
            s = s - (ADDR_W + 1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    in_t in_item;
    assign in_item = in_t'(s_tdata[IN_W-1:0]);

    // control state
    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // working payload
    logic [1:0]                  status_reg, status_next;
    logic signed [OUTV_W-1:0]    out_value_reg, out_value_next;
    logic signed [WORD_BITS-1:0] big_reg, big_next;
    logic signed [WORD_BITS-1:0] small_reg, small_next;
    logic                        pos_seen_reg, pos_seen_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]            evens_reg, evens_next;
    logic [CNT_W-1:0]            odds_reg, odds_next;
    logic                        neg_reg, neg_next;
    logic [DIV_W-1:0]            dq_reg, dq_next;     // dividend out, quotient in
    logic [CNT_W-1:0]            rem_reg, rem_next;
    res_t                        res_reg, res_next;

    // ram port
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    fqcs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_item.value[WORD_BITS-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // helpers
    logic                        s_acc;
    logic                        is_full_now;
    logic signed [WORD_BITS-1:0] entry;
    logic                        entry_pos;
    logic [SUM_W-1:0]            sum_mag;
    logic [CNT_W:0]              rem_sh;
    logic [CNT_W:0]              rem_diff;
    logic                        rem_ge;
    logic signed [DIV_W:0]       mean_full;

    assign s_acc       = s_tvalid && s_tready;
    assign is_full_now = (held_reg == CNT_W'(DEPTH));
    assign entry       = signed'(ram_rdata);
    assign entry_pos   = !entry[WORD_BITS-1] && (entry != '0);
    assign sum_mag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rem_sh      = {rem_reg, dq_reg[DIV_W-1]};
    assign rem_diff    = rem_sh - {1'b0, held_reg};
    assign rem_ge      = (rem_sh >= {1'b0, held_reg});
    assign mean_full   = neg_reg ? -signed'({1'b0, dq_reg}) : signed'({1'b0, dq_reg});

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        head_next      = head_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        div_cnt_next   = div_cnt_reg;
        status_next    = status_reg;
        out_value_next = out_value_reg;
        big_next       = big_reg;
        small_next     = small_reg;
        pos_seen_next  = pos_seen_reg;
        sum_next       = sum_reg;
        evens_next     = evens_reg;
        odds_next      = odds_reg;
        neg_next       = neg_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        ram_we         = 1'b0;
        ram_waddr      = wrap_add(head_reg, held_reg[ADDR_W-1:0]);
        ram_raddr      = wrap_add(head_reg, rd_idx_reg[ADDR_W-1:0]);

        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    // fresh statistics for this request
                    status_next    = ST_DONE;
                    out_value_next = '0;
                    big_next       = '0;
                    small_next     = '0;
                    pos_seen_next  = 1'b0;
                    sum_next       = '0;
                    evens_next     = '0;
                    odds_next      = '0;
                    neg_next       = 1'b0;
                    dq_next        = '0;
                    rd_idx_next    = '0;
                    pend_next      = 1'b0;
                    state_next     = S_WALK;
                    if (in_item.op == OP_ENQ)
                    begin
                        if (is_full_now)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            held_next = held_reg + 1'b1;
                        end
                    end
                    else if (in_item.op == OP_DEQ)
                    begin
                        if (held_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_raddr  = head_reg;
                            state_next = S_DEQ;
                        end
                    end
                end
            end

            S_DEQ:
            begin
                out_value_next = OUTV_W'(entry);
                head_next      = wrap_add(head_reg, ADDR_W'(1));
                held_next      = held_reg - 1'b1;
                state_next     = S_WALK;
            end

            S_WALK:
            begin
                if (pend_reg)
                begin
                    if (entry > big_reg)
                    begin
                        big_next = entry;
                    end
                    if (entry_pos && (!pos_seen_reg || entry < small_reg))
                    begin
                        small_next    = entry;
                        pos_seen_next = 1'b1;
                    end
                    sum_next = sum_reg + SUM_W'(entry);
                    if (entry[0])
                    begin
                        odds_next = odds_reg + 1'b1;
                    end
                    else
                    begin
                        evens_next = evens_reg + 1'b1;
                    end
                end
                if (rd_idx_reg < held_reg)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && (rd_idx_reg == held_reg))
                begin
                    if (held_reg == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        neg_next     = sum_reg[SUM_W-1];
                        dq_next      = {sum_mag, 8'd0};
                        rem_next     = '0;
                        div_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                rem_next     = rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                dq_next      = {dq_reg[DIV_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    res_next.status     = status_reg;
                    res_next.out_value  = out_value_reg;
                    res_next.fill_count = FILL_W'(held_reg);
                    res_next.is_full    = is_full_now;
                    res_next.is_empty   = (held_reg == '0);
                    res_next.largest    = LARGE_W'(big_reg[WORD_BITS-2:0]);
                    res_next.smallest   = pos_seen_reg ? LARGE_W'(small_reg[WORD_BITS-2:0])
                                                       : '0;
                    res_next.total      = TOTAL_W'(sum_reg);
                    res_next.mean_q8    = MEAN_W'(mean_full);
                    res_next.even_count = CNT4_W'(evens_reg);
                    res_next.odd_count  = CNT4_W'(odds_reg);
                    m_tvalid_next       = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            head_reg     <= '0;
            rd_idx_reg   <= '0;
            pend_reg     <= 1'b0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            head_reg     <= head_next;
            rd_idx_reg   <= rd_idx_next;
            pend_reg     <= pend_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        out_value_reg <= out_value_next;
        big_reg       <= big_next;
        small_reg     <= small_next;
        pos_seen_reg  <= pos_seen_next;
        sum_reg       <= sum_next;
        evens_reg     <= evens_next;
        odds_reg      <= odds_next;
        neg_reg       <= neg_next;
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(res_reg);

endmodule

`default_nettype wire

/* design/fqcs_checker.sv */
// port-level checker for the fifo queue with content statistics, bound to the top
// depends on fqcs_pkg and fifo_queue_with_content_stats_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_queue_with_content_stats_top_defines.svh"

module fqcs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [fqcs_pkg::IN_TDATA_W-1:0]   s_tdata,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [fqcs_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import fqcs_pkg::*;

    res_t res;
    logic in_seen;

    assign res     = res_t'(m_tdata[RES_W-1:0]);
    assign in_seen = (s_tdata != '0) || 1'b1;

    // one request at a time: busy right after a request is taken
    `FQCS_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready && in_seen, !s_tready, "ready right after request")

    // empty contents give zero statistics
    `FQCS_ASSERT_IMP(a_empty_zero, m_tvalid && res.is_empty, res.fill_count == '0 && res.total == '0 && res.mean_q8 == '0 && res.largest == '0, "empty result with stats")

    // a refused dequeue only happens on an empty queue and returns no word
    `FQCS_ASSERT_IMP(a_refused_empty, m_tvalid && res.status == ST_EMPTY, res.is_empty && res.out_value == '0, "bad refused dequeue")

    // a stalled result holds
    `FQCS_ASSERT_NXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

endmodule

bind fifo_queue_with_content_stats_top fqcs_checker u_fqcs_checker (.*);

`default_nettype wire

/* verif/tb.sv */
// self-checking testbench for fifo_queue_with_content_stats_top
// depends on fqcs_pkg and the design sources; drives requests, checks every result
`timescale 1ns / 1ps

module tb;

    import fqcs_pkg::*;

    localparam int QDEPTH = 8;
    localparam int QWORD  = 32;

    // op code 3 is unused by the design and must behave as report only
    localparam logic [1:0] OP_SPARE = 2'd3;

    // stimulus sizes in requests, stall windows placed by counts of accepted requests
    localparam int RANDOM_A    = 340;
    localparam int RANDOM_B    = 340;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_FROM   = 450;
    localparam int CALM_TO     = 560;

    // wait before the end of the run, long enough to clear the pipeline
    localparam int DRAIN_CYCLES = 100;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // requests waiting to be offered, results waiting to be seen
    in_t  pending_reqs[$];
    res_t expected_results[$];

    int pushed_cnt   = 0;
    int accepted_cnt = 0;
    int results_seen = 0;
    int errors       = 0;
    logic rx_hold    = 1'b0;

    // no random idling on either side inside this window of requests
    wire calm = (accepted_cnt >= CALM_FROM) && (accepted_cnt < CALM_TO);

    // shadow copy of the queue contents
    logic signed [QWORD-1:0] shadow_words [QDEPTH];
    int shadow_held = 0;

    fifo_queue_with_content_stats_top #(
        .DEPTH     (QDEPTH),
        .WORD_BITS (QWORD)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one request to the shadow queue and work out the statistics after it
    function automatic res_t queue_after_request(in_t req);
        res_t r;
        longint big;
        longint least;
        longint sum;
        longint mean;
        longint e;
        int evens;
        int odds;
        int k;
        r     = '0;
        big   = 0;
        least = 0;
        sum   = 0;
        mean  = 0;
        evens = 0;
        odds  = 0;
        r.status = ST_DONE;
        if (req.op == OP_ENQ)
        begin
            if (shadow_held >= QDEPTH)
                r.status = ST_FULL;
            else
            begin
                shadow_words[shadow_held] = req.value;
                shadow_held++;
            end
        end
        else if (req.op == OP_DEQ)
        begin
            if (shadow_held == 0)
                r.status = ST_EMPTY;
            else
            begin
                // head leaves, the rest move one place toward the head
                r.out_value = shadow_words[0];
                for (k = 0; k < shadow_held - 1; k++)
                    shadow_words[k] = shadow_words[k + 1];
                shadow_held--;
            end
        end
        // report only and the spare code leave the contents alone
        if (shadow_held > 0)
        begin
            for (k = 0; k < shadow_held; k++)
            begin
                e = shadow_words[k];
                if (e > big)
                    big = e;
            end
            // smallest starts at largest and only drops to positive entries
            least = big;
            for (k = 0; k < shadow_held; k++)
            begin
                e = shadow_words[k];
                if (e > 0 && e < least)
                    least = e;
                sum += e;
                if (e[0])
                    odds++;
                else
                    evens++;
            end
            // signed division truncates toward zero
            mean = (sum * 256) / shadow_held;
        end
        r.fill_count = shadow_held[FILL_W-1:0];
        r.is_full    = (shadow_held == QDEPTH);
        r.is_empty   = (shadow_held == 0);
        r.largest    = big[LARGE_W-1:0];
        r.smallest   = least[LARGE_W-1:0];
        r.total      = sum[TOTAL_W-1:0];
        r.mean_q8    = mean[MEAN_W-1:0];
        r.even_count = evens[CNT4_W-1:0];
        r.odd_count  = odds[CNT4_W-1:0];
        return r;
    endfunction

    // request driver: offers the next pending request, idles about 20% of the time
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        in_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                // accepted at this edge: predict its result now, order is preserved
                expected_results.push_back(queue_after_request(in_t'(s_tdata[IN_W-1:0])));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 20))
                begin
                    req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, req};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result sink: random back pressure plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && (calm || $urandom_range(99) >= 20);
    end

    // long receiver hold-off while the sender keeps offering, so the input stalls
    initial
    begin
        wait (accepted_cnt >= HOLD_AT);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic check_field(input string fname, input logic [39:0] want,
                               input logic [39:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            errors++;
        end
    endtask

    // result monitor: every accepted result against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[RES_W-1:0];
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding, expected none, actual %0h",
                         $time, m_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status",     want.status,     got.status);
                check_field("out_value",  want.out_value,  got.out_value);
                check_field("fill_count", want.fill_count, got.fill_count);
                check_field("is_full",    want.is_full,    got.is_full);
                check_field("is_empty",   want.is_empty,   got.is_empty);
                check_field("largest",    want.largest,    got.largest);
                check_field("smallest",   want.smallest,   got.smallest);
                check_field("total",      want.total,      got.total);
                check_field("mean_q8",    want.mean_q8,    got.mean_q8);
                check_field("even_count", want.even_count, got.even_count);
                check_field("odd_count",  want.odd_count,  got.odd_count);
            end
        end
    end

    task automatic add_req(input logic [1:0] op, input logic [31:0] v);
        in_t r;
        r.op    = op;
        r.value = v;
        pending_reqs.push_back(r);
        pushed_cnt++;
    endtask

    // word mix: full random, small signed, extremes, large positive, negative, small positive
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = $urandom;
            1: v = $urandom_range(16) - 8;
            2:
            begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            3: v = $urandom >> 1;
            4: v = 32'h8000_0000 | $urandom;
            default: v = $urandom_range(1000, 1);
        endcase
        return v;
    endfunction

    // random requests, mostly fill/drain bursts so the queue gets deep
    task automatic add_random(input int n);
        int stop_at;
        int k;
        int len;
        logic [31:0] v;
        stop_at = pushed_cnt + n;
        while (pushed_cnt < stop_at)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4:
                begin
                    // burst of enqueues then dequeues, reports and enqueues sprinkled in
                    len = $urandom_range(9, 1);
                    for (k = 0; k < len; k++)
                    begin
                        add_req(OP_ENQ, pick_value());
                        if ($urandom_range(4) == 0)
                            add_req(OP_RPT, $urandom);
                    end
                    len = $urandom_range(9, 1);
                    for (k = 0; k < len; k++)
                    begin
                        add_req(OP_DEQ, $urandom);
                        if ($urandom_range(5) == 0)
                            add_req(OP_ENQ, pick_value());
                    end
                end
                5, 6:
                begin
                    // fill with one repeated word, overfill, then drain past empty
                    v = pick_value();
                    for (k = 0; k <= QDEPTH; k++)
                        add_req(OP_ENQ, v);
                    add_req(OP_RPT, $urandom);
                    for (k = 0; k <= QDEPTH; k++)
                        add_req(OP_DEQ, $urandom);
                end
                default:
                begin
                    // noise: any op code, unused one included
                    len = $urandom_range(8, 1);
                    for (k = 0; k < len; k++)
                        add_req(2'($urandom_range(3)), $urandom);
                end
            endcase
        end
    endtask

    task automatic wait_for_all_results();
        while (results_seen != pushed_cnt)
            @(posedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        // report, dequeue and spare code on the empty queue
        add_req(OP_RPT,   32'h1234_5678);
        add_req(OP_DEQ,   32'hFFFF_FFFF);
        add_req(OP_SPARE, 32'h0000_0000);
        // fill with the word extremes and both parities
        add_req(OP_ENQ, 32'h7FFF_FFFF);
        add_req(OP_ENQ, 32'h8000_0000);
        add_req(OP_ENQ, 32'h0000_0000);
        add_req(OP_ENQ, 32'hFFFF_FFFF);
        add_req(OP_ENQ, 32'h0000_0001);
        add_req(OP_ENQ, 32'h0000_0002);
        add_req(OP_ENQ, 32'h7FFF_FFFE);
        add_req(OP_ENQ, 32'h0000_0005);
        // enqueue refused when full, then reports on the full queue
        add_req(OP_ENQ,   32'h0000_0003);
        add_req(OP_RPT,   32'hAAAA_5555);
        add_req(OP_SPARE, 32'h5555_AAAA);
        // drain to empty and one dequeue past it
        repeat (QDEPTH + 1) add_req(OP_DEQ, 32'h0000_0000);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // sender pauses here until every result is back
        wait_for_all_results();
        add_random(RANDOM_A);
        wait_for_all_results();
        add_random(RANDOM_B);
        wait_for_all_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
